[rtl/hid_keyboard_report_builder_unit_macros.svh]
// Assertion macros shared by the report builder.
// Each expects clk and rst_n in the scope where it is used.
`ifndef HID_KEYBOARD_REPORT_BUILDER_UNIT_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HKRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hkrb_pkg.sv]
`default_nettype none
package hkrb_pkg;

  localparam int KEY_SLOTS  = 6;
  localparam int CODE_W     = 8;
  localparam int PREFIX_LEN = 16;
  localparam int PREFIX_W   = $clog2(PREFIX_LEN);
  localparam int LINE_LEN   = PREFIX_LEN + 2 * (KEY_SLOTS + 2) + 2;
  localparam int IDX_W      = $clog2(LINE_LEN);
  localparam int BYTE_CNT   = KEY_SLOTS + 2;
  localparam int BYTE_IDX_W = $clog2(BYTE_CNT);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [4:0]        MOD_CODE_HI = 5'b11100;
  localparam logic [CODE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [CODE_W-1:0] CHAR_LF     = 8'h0A;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] key_code;
    logic              pressed;
  } hkrb_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_byte;
    logic              last;
  } hkrb_out_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOD_SET,
    OP_MOD_CLR,
    OP_KEY_PRESS,
    OP_KEY_RELEASE,
    OP_TICK
  } hkrb_op_t;

  typedef struct packed {
    hkrb_op_t          op;
    logic [CODE_W-1:0] code;
  } hkrb_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hkrb_q_stat_t;

  typedef struct packed {
    logic [CODE_W-1:0]                mods;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] slots;
  } hkrb_report_t;

  typedef enum logic {
    EM_IDLE,
    EM_SEND
  } hkrb_em_state_t;

  function automatic logic [CODE_W-1:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return 8'h37 + {4'h0, n};
  endfunction

  function automatic logic [CODE_W-1:0] prefix_char(input logic [PREFIX_W-1:0] i);
    logic [CODE_W-1:0] c;
    case (i)
      4'd0:    c = "A";
      4'd1:    c = "T";
      4'd2:    c = "+";
      4'd3:    c = "H";
      4'd4:    c = "I";
      4'd5:    c = "D";
      4'd6:    c = "S";
      4'd7:    c = "E";
      4'd8:    c = "N";
      4'd9:    c = "D";
      4'd10:   c = "=";
      4'd11:   c = "0";
      4'd12:   c = "x";
      4'd13:   c = "0";
      4'd14:   c = "1";
      4'd15:   c = ",";
      default: c = ",";
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/hid_keyboard_report_builder_unit.sv]
// A key event passes through the queue and is then registered into the report; a report
// tick that finds a changed report loads the serialiser, which registers each character.
// Throughput: one transaction per cycle unless the four-entry queue is full; a line is 34
// characters, one per cycle from the serialiser while the result side does not stall.
// A tick waits in the queue while the serialiser is still sending the previous line.
// Reset clears the report, the last sent report, the queue and the serialiser.
`default_nettype none
`include "hid_keyboard_report_builder_unit_macros.svh"
module hid_keyboard_report_builder_unit
  import hkrb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire hkrb_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output hkrb_out_t      out_data
);

  hkrb_q_stat_t q_stat;
  logic         push;
  hkrb_cmd_t    push_cmd;
  logic         pop;
  hkrb_cmd_t    pop_cmd;
  logic         em_ready;
  logic         em_load;
  hkrb_report_t em_report;

  hkrb_front u_front (
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  hkrb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  hkrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .cmd       (pop_cmd),
    .pop       (pop),
    .em_ready  (em_ready),
    .em_load   (em_load),
    .em_report (em_report)
  );

  hkrb_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .em_load   (em_load),
    .em_report (em_report),
    .em_ready  (em_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `HKRB_ASSERT_NOW(a_load_when_idle, em_load, em_ready, "line loaded while serialiser busy")
  `HKRB_ASSERT_NEXT(a_busy_after_load, em_load, !em_ready, "serialiser idle after a load")
  `HKRB_ASSERT_NOW(a_last_is_lf, out_valid && out_data.last, out_data.out_byte == CHAR_LF,
                   "last flag on a character other than LF")
  `HKRB_ASSERT_NOW(a_queue_state, q_stat.full, !q_stat.empty, "queue both full and empty")

endmodule
`default_nettype wire

[rtl/hkrb_front.sv]
`default_nettype none
module hkrb_front
  import hkrb_pkg::*;
(
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire hkrb_in_t     in_data,
  input  wire hkrb_q_stat_t q_stat,
  output logic              push,
  output hkrb_cmd_t         push_cmd
);

  hkrb_op_t op;

  always_comb begin
    if (in_data.func) begin
      op = OP_TICK;
    end else if (in_data.key_code == '0) begin
      op = OP_NOP;
    end else if (in_data.key_code[CODE_W-1:3] == MOD_CODE_HI) begin
      op = in_data.pressed ? OP_MOD_SET : OP_MOD_CLR;
    end else begin
      op = in_data.pressed ? OP_KEY_PRESS : OP_KEY_RELEASE;
    end
  end

  // Key transactions with a zero key code are not queued.
  assign in_stall      = q_stat.full || !rst_n;
  assign push          = in_valid && !in_stall && (op != OP_NOP);
  assign push_cmd.op   = op;
  assign push_cmd.code = in_data.key_code;

endmodule
`default_nettype wire

[rtl/hkrb_queue.sv]
`default_nettype none
module hkrb_queue
  import hkrb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire hkrb_cmd_t push_cmd,
  input  wire logic      pop,
  output hkrb_cmd_t      pop_cmd,
  output hkrb_q_stat_t   q_stat
);

  hkrb_cmd_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign q_stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cmd      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[rtl/hkrb_back.sv]
`default_nettype none
module hkrb_back
  import hkrb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire hkrb_q_stat_t q_stat,
  input  wire hkrb_cmd_t    cmd,
  output logic              pop,
  input  wire logic         em_ready,
  output logic              em_load,
  output hkrb_report_t      em_report
);

  hkrb_report_t         rpt_r, rpt_nxt;
  hkrb_report_t         sent_r, sent_nxt;
  logic [CODE_W-1:0]    mod_mask;
  logic                 hit;
  logic                 seen;
  logic [KEY_SLOTS-1:0] take;
  logic                 cmd_valid;

  assign cmd_valid = !q_stat.empty;
  assign mod_mask  = CODE_W'(1) << cmd.code[2:0];
  assign em_report = rpt_r;

  // A press takes the first empty slot only if no slot already holds the code.
  always_comb begin
    hit  = 1'b0;
    seen = 1'b0;
    take = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit = hit || (rpt_r.slots[i] == cmd.code);
      if (!seen && rpt_r.slots[i] == '0) begin
        take[i] = 1'b1;
      end
      seen = seen || (rpt_r.slots[i] == '0);
    end
  end

  always_comb begin
    rpt_nxt  = rpt_r;
    sent_nxt = sent_r;
    pop      = 1'b0;
    em_load  = 1'b0;
    case (cmd.op)
      OP_MOD_SET: begin
        pop = cmd_valid;
        if (cmd_valid) begin
          rpt_nxt.mods = rpt_r.mods | mod_mask;
        end
      end
      OP_MOD_CLR: begin
        pop = cmd_valid;
        if (cmd_valid) begin
          rpt_nxt.mods = rpt_r.mods & ~mod_mask;
        end
      end
      OP_KEY_PRESS: begin
        pop = cmd_valid;
        if (cmd_valid && !hit) begin
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (take[i]) begin
              rpt_nxt.slots[i] = cmd.code;
            end
          end
        end
      end
      OP_KEY_RELEASE: begin
        pop = cmd_valid;
        if (cmd_valid) begin
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (rpt_r.slots[i] == cmd.code) begin
              rpt_nxt.slots[i] = '0;
            end
          end
        end
      end
      OP_TICK: begin
        pop = cmd_valid && em_ready;
        if (cmd_valid && em_ready && (rpt_r != sent_r)) begin
          em_load  = 1'b1;
          sent_nxt = rpt_r;
        end
      end
      default: begin
        pop = cmd_valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_r  <= '0;
      sent_r <= '0;
    end else begin
      rpt_r  <= rpt_nxt;
      sent_r <= sent_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/hkrb_emitter.sv]
`default_nettype none
module hkrb_emitter
  import hkrb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         em_load,
  input  wire hkrb_report_t em_report,
  output logic              em_ready,
  output logic              out_valid,
  input  wire logic         out_stall,
  output hkrb_out_t         out_data
);

  hkrb_em_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]           idx_r;
  logic [BYTE_CNT-1:0][CODE_W-1:0] snap_r;
  logic                       out_valid_r;
  hkrb_out_t                  out_data_r;
  logic                       adv;
  logic [IDX_W-1:0]           pos;
  logic [BYTE_IDX_W-1:0]      byte_idx;
  logic [CODE_W-1:0]          cur_byte;
  logic [CODE_W-1:0]          next_char;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: begin
        if (em_load) begin
          state_nxt = EM_SEND;
        end
      end
      EM_SEND: begin
        if (adv && idx_r == IDX_W'(LINE_LEN - 1)) begin
          state_nxt = EM_IDLE;
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    em_ready = (state_r == EM_IDLE);
    adv      = (state_r == EM_SEND) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    pos      = idx_r - IDX_W'(PREFIX_LEN);
    byte_idx = BYTE_IDX_W'(pos >> 1);
    cur_byte = snap_r[byte_idx];
    if (idx_r < IDX_W'(PREFIX_LEN)) begin
      next_char = prefix_char(idx_r[PREFIX_W-1:0]);
    end else if (idx_r == IDX_W'(LINE_LEN - 2)) begin
      next_char = CHAR_CR;
    end else if (idx_r == IDX_W'(LINE_LEN - 1)) begin
      next_char = CHAR_LF;
    end else if (pos[0]) begin
      next_char = hex_char(cur_byte[3:0]);
    end else begin
      next_char = hex_char(cur_byte[7:4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (em_load && em_ready) begin
        idx_r <= '0;
      end else if (adv) begin
        idx_r <= idx_r + 1'b1;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Snapshot order: modifier byte, reserved byte, then the key slots.
  always_ff @(posedge clk) begin
    if (em_load && em_ready) begin
      snap_r[0] <= em_report.mods;
      snap_r[1] <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        snap_r[i + 2] <= em_report.slots[i];
      end
    end
    if (adv) begin
      out_data_r.out_byte <= next_char;
      out_data_r.last     <= (idx_r == IDX_W'(LINE_LEN - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[test/hid_keyboard_report_builder_unit_tb.sv]
module hid_keyboard_report_builder_unit_tb;
  import hkrb_pkg::*;

  localparam logic              FUNC_KEY   = 1'b0;
  localparam logic              FUNC_TICK  = 1'b1;
  localparam logic [CODE_W-1:0] MOD_FIRST  = 8'hE0;
  localparam logic [CODE_W-1:0] MOD_LAST   = 8'hE7;
  localparam logic [CODE_W-1:0] NO_KEY     = 8'h00;
  localparam logic [CODE_W-1:0] POOL_BASE  = 8'h04;
  localparam logic [8*16-1:0]   LINE_HEAD  = "AT+HIDSEND=0x01,";
  localparam int                HOLD_LEN   = 400;
  localparam int                CYCLE_MAX  = 600000;
  localparam int                PRINT_MAX  = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hkrb_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hkrb_out_t out_data;

  hkrb_in_t  key_events_q[$];
  hkrb_out_t expected_chars[$];

  logic [CODE_W-1:0] mods_now = '0;
  logic [CODE_W-1:0] mods_sent = '0;
  logic [CODE_W-1:0] slots_now [KEY_SLOTS];
  logic [CODE_W-1:0] slots_sent [KEY_SLOTS];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_on = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;
  int cycle_cnt = 0;
  int errors = 0;
  int accepted = 0;
  int lines_sent = 0;
  int quiet_ticks = 0;
  int dropped_presses = 0;
  int chars_checked = 0;

  hid_keyboard_report_builder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      slots_now[i] = '0;
      slots_sent[i] = '0;
    end
  end

  function automatic logic [CODE_W-1:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end
    return 8'h41 + {4'h0, n} - 8'd10;
  endfunction

  task automatic queue_char(input logic [CODE_W-1:0] c, input logic fin);
    hkrb_out_t r;
    r.out_byte = c;
    r.last = fin;
    expected_chars.push_back(r);
  endtask

  task automatic queue_hex(input logic [CODE_W-1:0] v);
    queue_char(hex_digit(v[7:4]), 1'b0);
    queue_char(hex_digit(v[3:0]), 1'b0);
  endtask

  task automatic update_report(input hkrb_in_t t);
    logic changed;
    logic held;
    logic placed;
    changed = 1'b0;
    held = 1'b0;
    placed = 1'b0;
    if (t.func == FUNC_TICK) begin
      changed = (mods_now != mods_sent);
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (slots_now[i] != slots_sent[i]) begin
          changed = 1'b1;
        end
      end
      if (changed) begin
        for (int i = 0; i < 16; i++) begin
          queue_char(LINE_HEAD[8*(15-i) +: 8], 1'b0);
        end
        queue_hex(mods_now);
        queue_hex(8'h00);
        for (int i = 0; i < KEY_SLOTS; i++) begin
          queue_hex(slots_now[i]);
        end
        queue_char(CHAR_CR, 1'b0);
        queue_char(CHAR_LF, 1'b1);
        mods_sent = mods_now;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          slots_sent[i] = slots_now[i];
        end
        lines_sent++;
      end else begin
        quiet_ticks++;
      end
    end else if (t.key_code == NO_KEY) begin
    end else if (t.key_code >= MOD_FIRST && t.key_code <= MOD_LAST) begin
      mods_now[t.key_code[2:0]] = t.pressed;
    end else if (t.pressed) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (slots_now[i] == t.key_code) begin
          held = 1'b1;
        end
      end
      if (!held) begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!placed && slots_now[i] == NO_KEY) begin
            slots_now[i] = t.key_code;
            placed = 1'b1;
          end
        end
        if (!placed) begin
          dropped_presses++;
        end
      end
    end else begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (slots_now[i] == t.key_code) begin
          slots_now[i] = NO_KEY;
        end
      end
    end
  endtask

  task automatic queue_key(input logic [CODE_W-1:0] code, input logic down);
    hkrb_in_t t;
    t.func = FUNC_KEY;
    t.key_code = code;
    t.pressed = down;
    key_events_q.push_back(t);
  endtask

  task automatic queue_tick();
    hkrb_in_t t;
    t.func = FUNC_TICK;
    t.key_code = CODE_W'($urandom_range(255));
    t.pressed = 1'($urandom_range(1));
    key_events_q.push_back(t);
  endtask

  task automatic queue_random(input int count);
    hkrb_in_t t;
    int sel;
    for (int k = 0; k < count; k++) begin
      t.func = ($urandom_range(99) < 25) ? FUNC_TICK : FUNC_KEY;
      t.pressed = ($urandom_range(99) < 55);
      sel = $urandom_range(99);
      if (sel < 45) begin
        t.key_code = POOL_BASE + CODE_W'($urandom_range(9));
      end else if (sel < 65) begin
        t.key_code = MOD_FIRST + CODE_W'($urandom_range(7));
      end else if (sel < 70) begin
        t.key_code = NO_KEY;
      end else begin
        t.key_code = CODE_W'($urandom_range(255));
      end
      key_events_q.push_back(t);
    end
  endtask

  task automatic wait_for_idle();
    while (key_events_q.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
  endtask

  always @(posedge clk) begin
    logic offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        update_report(in_data);
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        offer = (key_events_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          in_data <= key_events_q.pop_front();
        end
        in_valid <= offer;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_on && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN - 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      if (!hold_on) begin
        hold_cnt <= 0;
        hold_done <= 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    hkrb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= PRINT_MAX) begin
          $display("%0t: unexpected character, expected none, got %h last %b",
                   $time, out_data.out_byte, out_data.last);
        end
      end else begin
        want = expected_chars.pop_front();
        if (want.out_byte != out_data.out_byte) begin
          errors++;
          if (errors <= PRINT_MAX) begin
            $display("%0t: out_byte expected %h, got %h", $time, want.out_byte,
                     out_data.out_byte);
          end
        end
        if (want.last != out_data.last) begin
          errors++;
          if (errors <= PRINT_MAX) begin
            $display("%0t: last expected %b, got %b", $time, want.last, out_data.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("%0t: timed out with %0d characters outstanding", $time,
               expected_chars.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed transactions: corner cases of the slot and modifier logic.
    queue_tick();
    queue_key(NO_KEY, 1'b1);
    queue_key(MOD_FIRST, 1'b1);
    queue_key(MOD_LAST, 1'b1);
    queue_tick();
    queue_key(8'h04, 1'b1);
    queue_key(8'h04, 1'b1);
    queue_key(8'h05, 1'b1);
    queue_key(8'h06, 1'b1);
    queue_key(8'h07, 1'b1);
    queue_key(8'h08, 1'b1);
    queue_key(8'hFF, 1'b1);
    queue_key(8'h09, 1'b1);
    queue_tick();
    queue_key(8'h2A, 1'b0);
    queue_key(8'hE3, 1'b0);
    queue_key(8'h04, 1'b0);
    queue_key(8'hFF, 1'b1);
    queue_key(8'h09, 1'b1);
    queue_tick();
    queue_tick();
    queue_key(MOD_FIRST, 1'b0);
    queue_key(MOD_LAST, 1'b0);
    queue_key(NO_KEY, 1'b0);
    queue_key(8'h09, 1'b0);
    queue_tick();
    wait_for_idle();

    // A run of report changes while the result side is held off.
    for (int k = 0; k < 8; k++) begin
      queue_key(POOL_BASE + CODE_W'(k), 1'b1);
      queue_tick();
      queue_key(POOL_BASE + CODE_W'(k), 1'b0);
      queue_tick();
    end
    queue_random(50);
    hold_on = 1'b1;
    while (!hold_done) begin
      @(negedge clk);
    end
    hold_on = 1'b0;
    wait_for_idle();

    send_idle_pct = 84;
    recv_stall_pct = 0;
    queue_random(110);
    wait_for_idle();

    send_idle_pct = 0;
    recv_stall_pct = 84;
    queue_random(110);
    wait_for_idle();

    send_idle_pct = 18;
    recv_stall_pct = 18;
    queue_random(120);
    wait_for_idle();
    repeat (40) @(posedge clk);

    $display("Run covered %0d transactions: %0d report lines, %0d unchanged ticks,",
             accepted, lines_sent, quiet_ticks);
    $display("%0d presses dropped on full slots, %0d characters checked.",
             dropped_presses, chars_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/hkrb_pkg.sv
rtl/hkrb_front.sv
rtl/hkrb_queue.sv
rtl/hkrb_back.sv
rtl/hkrb_emitter.sv
rtl/hid_keyboard_report_builder_unit.sv
test/hid_keyboard_report_builder_unit_tb.sv
